// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/arf_pkg.sv =====
// ----------------------------------------------------------------------------
// arf_pkg
// Types, constants and helpers for the auto rate fallback selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arf_pkg;

    localparam int DEF_NUM_RATES  = 8;
    localparam int CNT_W          = 8;
    localparam int CFG_DATA_W     = 8;
    localparam int CFG_IDX_W      = 2;

    localparam logic [7:0] RST_SUCC_THR = 8'd10;
    localparam logic [7:0] RST_FAIL_THR = 8'd2;
    localparam logic [3:0] RST_RETRY    = 4'd7;
    localparam logic [2:0] RST_LOWEST   = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUCC_THR = 2'd0,
        CFG_FAIL_THR = 2'd1,
        CFG_RETRY    = 2'd2,
        CFG_LOWEST   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_DOWN = 2'd1,
        MOVE_UP   = 2'd2
    } t_move;

    typedef struct packed {
        logic [7:0] succ_thr;
        logic [7:0] fail_thr;
        logic [3:0] retry_limit;
        logic [2:0] lowest_rate;
    } t_cfg;

    typedef struct packed {
        logic acked;
        logic later_stage_used;
        logic min_rate_frame;
    } t_status;

    typedef struct packed {
        logic [2:0] first_rate;
        logic [2:0] fallback_rate;
        logic [3:0] fallback_tries;
        t_move      rate_move;
    } t_plan;

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/arf_status_if.sv =====
// ----------------------------------------------------------------------------
// arf_status_if
// Transmit-status word channel: valid/ready with report flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arf_status_if;
    logic valid;
    logic ready;
    logic acked;
    logic later_stage_used;
    logic min_rate_frame;

    modport source (output valid, acked, later_stage_used, min_rate_frame, input ready);
    modport sink   (input valid, acked, later_stage_used, min_rate_frame, output ready);
endinterface

// ===== rtl/arf_plan_if.sv =====
// ----------------------------------------------------------------------------
// arf_plan_if
// Rate plan word channel: valid/ready with plan fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arf_plan_if;
    logic       valid;
    logic       ready;
    logic [2:0] first_rate;
    logic [2:0] fallback_rate;
    logic [3:0] fallback_tries;
    logic [1:0] rate_move;

    modport source (output valid, first_rate, fallback_rate, fallback_tries, rate_move,
                    input ready);
    modport sink   (input valid, first_rate, fallback_rate, fallback_tries, rate_move,
                    output ready);
endinterface

// ===== rtl/arf_in_stage.sv =====
// ----------------------------------------------------------------------------
// arf_in_stage
// Input register for status words; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arf_in_stage
    import arf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    arf_status_if.sink    s_in,
    input  logic          i_take,
    output logic          o_valid,
    output t_status       o_word
);

    logic    r_valid;
    t_status r_word;
    logic    accept;

    assign s_in.ready = !r_valid || i_take;
    assign accept     = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= '{acked:            s_in.acked,
                        later_stage_used: s_in.later_stage_used,
                        min_rate_frame:   s_in.min_rate_frame};
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/arf_rate_ctrl.sv =====
// ----------------------------------------------------------------------------
// arf_rate_ctrl
// Current rate and per-rate success/failure counters; at most one update per word, none for min_rate_frame words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arf_rate_ctrl
    import arf_pkg::*;
#(
    parameter int NUM_RATES = DEF_NUM_RATES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  t_status                      i_word,
    input  t_cfg                         i_cfg,
    output t_plan                        o_plan,
    output logic [$clog2(NUM_RATES)-1:0] o_cur_rate
);

    localparam int RW = $clog2(NUM_RATES);
    localparam int LW = (RW > 3) ? RW : 3;

    logic [RW-1:0]    r_cur;
    logic [RW-1:0]    n_cur;
    logic [CNT_W-1:0] r_succ [NUM_RATES];
    logic [CNT_W-1:0] r_fail [NUM_RATES];

    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] fc;
    logic [CNT_W-1:0] sc_new;
    logic [CNT_W-1:0] fc_new;
    logic [CNT_W-1:0] preset_val;
    logic             preset_en;
    logic [RW-1:0]    cr_up;
    logic             at_low;
    logic             at_top;
    logic             at_bot;
    logic             update;
    t_move            move;
    logic [LW-1:0]    cur_ext;

    assign update = i_fire && !i_word.min_rate_frame;

    always_comb begin
        sc         = r_succ[r_cur];
        fc         = r_fail[r_cur];
        at_low     = (LW'(r_cur) == LW'(i_cfg.lowest_rate));
        at_top     = (r_cur == RW'(NUM_RATES - 1));
        at_bot     = (r_cur == '0);
        cr_up      = r_cur + RW'(1);
        preset_val = (i_cfg.fail_thr == '0) ? '0 : i_cfg.fail_thr - 8'd1;
        preset_en  = 1'b0;
        n_cur      = r_cur;
        move       = MOVE_NONE;
        if (i_word.later_stage_used) begin
            sc_new = at_low ? CNT_W'(i_word.acked) : '0;
            fc_new = at_low ? fc : f_sat_inc(fc);
            if (fc_new >= i_cfg.fail_thr) begin
                fc_new = '0;
                if (!at_bot) begin
                    n_cur = r_cur - RW'(1);
                    move  = MOVE_DOWN;
                end
            end
        end else begin
            fc_new = '0;
            sc_new = f_sat_inc(sc);
            if (sc_new >= i_cfg.succ_thr) begin
                sc_new = '0;
                if (!at_top) begin
                    n_cur     = cr_up;
                    move      = MOVE_UP;
                    preset_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            for (int i = 0; i < NUM_RATES; i++) begin
                r_succ[i] <= '0;
                r_fail[i] <= '0;
            end
        end else if (update) begin
            r_cur         <= n_cur;
            r_succ[r_cur] <= sc_new;
            r_fail[r_cur] <= fc_new;
            if (preset_en) begin
                r_fail[cr_up] <= preset_val;
            end
        end
    end

    assign cur_ext = LW'(n_cur);

    assign o_plan = '{first_rate:     cur_ext[2:0],
                      fallback_rate:  i_cfg.lowest_rate,
                      fallback_tries: i_cfg.retry_limit,
                      rate_move:      move};

    assign o_cur_rate = r_cur;

endmodule

// ===== rtl/arf_out_reg.sv =====
// ----------------------------------------------------------------------------
// arf_out_reg
// Result register driving the plan channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arf_out_reg
    import arf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_plan       i_plan,
    arf_plan_if.source  m_out,
    output logic        o_space
);

    logic  r_valid;
    t_plan r_plan;

    assign o_space = !r_valid || m_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_plan <= i_plan;
        end
    end

    assign m_out.valid          = r_valid;
    assign m_out.first_rate     = r_plan.first_rate;
    assign m_out.fallback_rate  = r_plan.fallback_rate;
    assign m_out.fallback_tries = r_plan.fallback_tries;
    assign m_out.rate_move      = r_plan.rate_move;

endmodule

// ===== rtl/auto_rate_fallback_selector_core.sv =====
// ----------------------------------------------------------------------------
// auto_rate_fallback_selector_core
// Adapted ARF rate selector: one status word in, at most one rate plan word out.
//
//  channel    dir  fields
//  i_status   in   acked, later_stage_used, min_rate_frame
//  o_plan     out  first_rate, fallback_rate, fallback_tries, rate_move
//  i_cfg_*    in   we, idx (0..3), data (8 bits)
//
// One word per cycle sustained while o_plan is ready.
// The rate/counter update is combinational between the input and result registers.
// Words with min_rate_frame set drain without producing a plan word, even on a stall.
// Other words hold the input register on a stall; reset clears all counters at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module auto_rate_fallback_selector_core
    import arf_pkg::*;
#(
    parameter int NUM_RATES = DEF_NUM_RATES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    arf_status_if.sink            i_status,
    arf_plan_if.source            o_plan
);

    localparam int RW = $clog2(NUM_RATES);

    t_cfg          r_cfg;
    logic          in_valid;
    t_status       in_word;
    logic          space;
    logic          take;
    logic          fire;
    t_plan         plan;
    logic [RW-1:0] cur_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{succ_thr:    RST_SUCC_THR,
                       fail_thr:    RST_FAIL_THR,
                       retry_limit: RST_RETRY,
                       lowest_rate: RST_LOWEST};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SUCC_THR: r_cfg.succ_thr    <= i_cfg_data;
                CFG_FAIL_THR: r_cfg.fail_thr    <= i_cfg_data;
                CFG_RETRY:    r_cfg.retry_limit <= i_cfg_data[3:0];
                CFG_LOWEST:   r_cfg.lowest_rate <= i_cfg_data[2:0];
                default:      r_cfg             <= r_cfg;
            endcase
        end
    end

    assign take = in_valid && (in_word.min_rate_frame || space);
    assign fire = take;

    arf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (i_status),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    arf_rate_ctrl #(
        .NUM_RATES (NUM_RATES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_word     (in_word),
        .i_cfg      (r_cfg),
        .o_plan     (plan),
        .o_cur_rate (cur_rate)
    );

    arf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && !in_word.min_rate_frame),
        .i_plan  (plan),
        .m_out   (o_plan),
        .o_space (space)
    );

    `ASSERT_ALWAYS(a_rate_in_range, cur_rate <= RW'(NUM_RATES - 1), "rate out of range")
    `ASSERT_NEXT(a_counted_emits, fire && !in_word.min_rate_frame, o_plan.valid, "plan lost")
    `ASSERT_NEXT(a_ignored_holds, fire && in_word.min_rate_frame, $stable(cur_rate),
        "ignored word moved rate")

endmodule
